>>> rtl/core/hvd_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the haversine distance pipeline.
// No dependencies; every other file in rtl/core imports this package.
package hvd_pkg;

	localparam int CORDIC_STEPS   = 24;
	localparam int EARTH_RADIUS_M = 6371000;

	// CORDIC datapath width: Q30 values with headroom for gain and sign
	localparam int XW = 34;
	// digit steps of the floor square root (62-bit radicand, two bits per step)
	localparam int SQRT_STEPS = 31;

	typedef logic signed [XW-1:0] cw_t;

	typedef struct packed {
		logic valid;
		logic no_pos;
	} ctl_t;

	localparam logic signed [XW-1:0] Q30_ONE      = 34'sd1073741824;
	localparam logic signed [XW-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic [33:0]          PI_Q30       = 34'd3373259426;

	// 1e-7 degree to Q30 radians, scaled by 2^32; split for two narrow multipliers
	localparam logic [33:0] UNIT_TO_RAD_Q62 = 34'd8048910509;
	localparam logic [17:0] K_HI = UNIT_TO_RAD_Q62[33:16];
	localparam logic [15:0] K_LO = UNIT_TO_RAD_Q62[15:0];

	localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
	localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
	localparam logic signed [32:0] LON_HALF  = 33'sd1800000000;
	localparam logic signed [32:0] LON_TURN  = 33'sd3600000000;

	localparam logic [22:0] RADIUS   = 23'(EARTH_RADIUS_M);
	localparam logic [24:0] DIST_CAP = 25'((64'(EARTH_RADIUS_M) * 64'(PI_Q30)) >> 30);

	// atan(2^-i) in Q30, truncated
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] r;
		case (i)
			0:  r = 30'd843314856;
			1:  r = 30'd497837829;
			2:  r = 30'd263043836;
			3:  r = 30'd133525158;
			4:  r = 30'd67021686;
			5:  r = 30'd33543515;
			6:  r = 30'd16775850;
			7:  r = 30'd8388437;
			8:  r = 30'd4194282;
			9:  r = 30'd2097149;
			10: r = 30'd1048575;
			11: r = 30'd524287;
			12: r = 30'd262143;
			13: r = 30'd131071;
			14: r = 30'd65535;
			15: r = 30'd32767;
			16: r = 30'd16383;
			17: r = 30'd8191;
			18: r = 30'd4095;
			19: r = 30'd2047;
			20: r = 30'd1023;
			21: r = 30'd511;
			22: r = 30'd255;
			23: r = 30'd127;
			24: r = 30'd63;
			25: r = 30'd31;
			26: r = 30'd15;
			27: r = 30'd8;
			28: r = 30'd4;
			29: r = 30'd2;
			30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/hvd_front.sv
// Input conditioning: clamp, coordinate differences, longitude wrap, conversion to Q30 radians.
// Three register stages. Depends on hvd_pkg.
module hvd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_in,
	input  logic signed [30:0]  here_lat,
	input  logic signed [31:0]  here_lon,
	input  logic signed [30:0]  goal_lat,
	input  logic signed [31:0]  goal_lon,
	output hvd_pkg::ctl_t       ctl_out,
	output logic signed [31:0]  ang [4]
);
	import hvd_pkg::*;

	logic signed [30:0] lat1, lat2;
	logic signed [31:0] lon1, lon2;
	logic signed [32:0] dlat, dlon, dlon_w;
	logic signed [32:0] val [4];

	ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic [30:0] mag_s1 [4];
	logic        neg_s1 [4];
	logic [48:0] hi_s2 [4];
	logic [46:0] lo_s2 [4];
	logic        neg_s2 [4];
	logic signed [31:0] ang_s3 [4];

	always_comb begin
		lat1 = (here_lat > LAT_LIMIT) ? LAT_LIMIT : ((here_lat < -LAT_LIMIT) ? -LAT_LIMIT : here_lat);
		lat2 = (goal_lat > LAT_LIMIT) ? LAT_LIMIT : ((goal_lat < -LAT_LIMIT) ? -LAT_LIMIT : goal_lat);
		lon1 = (here_lon > LON_LIMIT) ? LON_LIMIT : ((here_lon < -LON_LIMIT) ? -LON_LIMIT : here_lon);
		lon2 = (goal_lon > LON_LIMIT) ? LON_LIMIT : ((goal_lon < -LON_LIMIT) ? -LON_LIMIT : goal_lon);
		dlat = 33'(lat2) - 33'(lat1);
		dlon = 33'(lon2) - 33'(lon1);
		if (dlon > LON_HALF)
			dlon_w = dlon - LON_TURN;
		else if (dlon < -LON_HALF)
			dlon_w = dlon + LON_TURN;
		else
			dlon_w = dlon;
		val[0] = 33'(lat1);
		val[1] = 33'(lat2);
		val[2] = dlat;
		val[3] = dlon_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1.valid  <= valid_in;
			ctl_s1.no_pos <= (here_lat == '0) || (here_lon == '0);
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// conversion multiplies magnitudes; sign is restored after rounding
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 4; l++) begin
				neg_s1[l] <= val[l] < 0;
				mag_s1[l] <= (val[l] < 0) ? 31'(-val[l]) : 31'(val[l]);
				hi_s2[l]  <= 49'(mag_s1[l]) * 49'(K_HI);
				lo_s2[l]  <= 47'(mag_s1[l]) * 47'(K_LO);
				neg_s2[l] <= neg_s1[l];
			end
		end
	end

	// latitudes keep full angle, differences are halved (one more bit of shift)
	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [64:0] full, rnd;
		logic [31:0] r;
		always_comb begin
			full = {hi_s2[l], 16'b0} + 65'(lo_s2[l]);
			if (l < 2) begin
				rnd = full + (65'd1 << 31);
				r   = rnd[63:32];
			end else begin
				rnd = full + (65'd1 << 32);
				r   = rnd[64:33];
			end
		end
		always_ff @(posedge clk) begin
			if (adv)
				ang_s3[l] <= neg_s2[l] ? -$signed(r) : $signed(r);
		end
		assign ang[l] = ang_s3[l];
	end

	assign ctl_out = ctl_s3;

endmodule

>>> rtl/core/hvd_rot.sv
// Four-lane rotation-mode CORDIC, one micro-rotation per register stage: sine and cosine.
// Depends on hvd_pkg.
module hvd_rot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  hvd_pkg::ctl_t      ctl_in,
	input  logic signed [31:0] ang [4],
	output hvd_pkg::ctl_t      ctl_out,
	output hvd_pkg::cw_t       sin_v [4],
	output hvd_pkg::cw_t       cos_v [4]
);
	import hvd_pkg::*;

	ctl_t c_s [CORDIC_STEPS+1];
	cw_t  x_s [CORDIC_STEPS+1][4];
	cw_t  y_s [CORDIC_STEPS+1][4];
	cw_t  z_s [CORDIC_STEPS+1][4];

	assign c_s[0] = ctl_in;
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			x_s[0][l] = INV_GAIN_Q30;
			y_s[0][l] = '0;
			z_s[0][l] = XW'(ang[l]);
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		localparam logic signed [XW-1:0] AT = $signed({{(XW-30){1'b0}}, atan_q30(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c_s[i+1] <= '0;
			else if (adv)
				c_s[i+1] <= c_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 4; l++) begin
					if (z_s[i][l] >= 0) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - AT;
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + AT;
					end
				end
			end
		end
	end

	assign ctl_out = c_s[CORDIC_STEPS];
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sin_v[l] = y_s[CORDIC_STEPS][l];
			cos_v[l] = x_s[CORDIC_STEPS][l];
		end
	end

endmodule

>>> rtl/core/hvd_sqrt.sv
// Two-lane pipelined floor square root of v * 2^30, one result bit per register stage.
// Depends on hvd_pkg.
module hvd_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  hvd_pkg::ctl_t ctl_in,
	input  logic [30:0]   v [2],
	output hvd_pkg::ctl_t ctl_out,
	output logic [30:0]   root [2]
);
	import hvd_pkg::*;

	ctl_t        c_s    [SQRT_STEPS+1];
	logic [61:0] rad_s  [SQRT_STEPS+1][2];
	logic [32:0] rem_s  [SQRT_STEPS+1][2];
	logic [30:0] root_s [SQRT_STEPS+1][2];

	assign c_s[0] = ctl_in;
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rad_s[0][l]  = {1'b0, v[l], 30'b0};
			rem_s[0][l]  = '0;
			root_s[0][l] = '0;
		end
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
		logic [34:0] rn [2];
		logic [34:0] tr [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				rn[l] = {rem_s[i][l], rad_s[i][l][61:60]};
				tr[l] = {2'b00, root_s[i][l], 2'b01};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c_s[i+1] <= '0;
			else if (adv)
				c_s[i+1] <= c_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 2; l++) begin
					rad_s[i+1][l] <= {rad_s[i][l][59:0], 2'b00};
					if (rn[l] >= tr[l]) begin
						rem_s[i+1][l]  <= 33'(rn[l] - tr[l]);
						root_s[i+1][l] <= {root_s[i][l][29:0], 1'b1};
					end else begin
						rem_s[i+1][l]  <= rn[l][32:0];
						root_s[i+1][l] <= {root_s[i][l][29:0], 1'b0};
					end
				end
			end
		end
	end

	assign ctl_out = c_s[SQRT_STEPS];
	assign root[0] = root_s[SQRT_STEPS][0];
	assign root[1] = root_s[SQRT_STEPS][1];

endmodule

>>> rtl/core/hvd_vec.sv
// Vectoring-mode CORDIC, one micro-rotation per register stage: angle of (x, y) for x, y >= 0.
// Depends on hvd_pkg.
module hvd_vec (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  hvd_pkg::ctl_t ctl_in,
	input  logic [30:0]   x_in,
	input  logic [30:0]   y_in,
	output hvd_pkg::ctl_t ctl_out,
	output hvd_pkg::cw_t  z_out
);
	import hvd_pkg::*;

	ctl_t c_s [CORDIC_STEPS+1];
	cw_t  x_s [CORDIC_STEPS+1];
	cw_t  y_s [CORDIC_STEPS+1];
	cw_t  z_s [CORDIC_STEPS+1];

	assign c_s[0] = ctl_in;
	assign x_s[0] = $signed(XW'(x_in));
	assign y_s[0] = $signed(XW'(y_in));
	assign z_s[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		localparam logic signed [XW-1:0] AT = $signed({{(XW-30){1'b0}}, atan_q30(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				c_s[i+1] <= '0;
			else if (adv)
				c_s[i+1] <= c_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end
			end
		end
	end

	assign ctl_out = c_s[CORDIC_STEPS];
	assign z_out   = z_s[CORDIC_STEPS];

endmodule

>>> rtl/core/haversine_distance.sv
// Haversine great-circle distance, fully pipelined; register stages in order: 3 conversion,
// 24 sin/cos CORDIC, 4 products, 31 square root, 24 atan2 CORDIC, 3 scaling/output.
// Throughput one request per cycle; a stall on the output freezes the whole pipeline.
// arst_n clears every valid bit, so in_ready is high when reset is released.
// Depends on hvd_pkg, hvd_front, hvd_rot, hvd_sqrt, hvd_vec.
module haversine_distance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [30:0] here_lat,
	input  logic signed [31:0] here_lon,
	input  logic signed [30:0] goal_lat,
	input  logic signed [31:0] goal_lon,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [24:0]        distance_m,
	output logic               no_position
);
	import hvd_pkg::*;

	logic adv;
	ctl_t ctl_f, ctl_r, ctl_q, ctl_v;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [31:0] ang [4];
	cw_t  sin_v [4];
	cw_t  cos_v [4];
	logic [30:0] sq_in [2];
	logic [30:0] sq_out [2];
	cw_t  z_v;

	logic [30:0] c1_s1, c2_s1, sf_s1, sl_s1;
	logic [30:0] t1_s2, c12_s2, sl2_s2;
	logic [30:0] t1_s3, t2_s3;
	logic [30:0] a_s4;
	logic [30:0] ang_s5;
	logic [25:0] dist_s6;
	logic [31:0] sum;

	function automatic logic [30:0] clamp_pos(input cw_t v);
		if (v < 0)
			return '0;
		else if (v > Q30_ONE)
			return 31'(Q30_ONE);
		else
			return v[30:0];
	endfunction

	// |clamp(v, -1, 1)|
	function automatic logic [30:0] clamp_abs(input cw_t v);
		if (v > Q30_ONE || v < -Q30_ONE)
			return 31'(Q30_ONE);
		else if (v < 0)
			return 31'(-v);
		else
			return v[30:0];
	endfunction

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	hvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (in_valid),
		.here_lat (here_lat),
		.here_lon (here_lon),
		.goal_lat (goal_lat),
		.goal_lon (goal_lon),
		.ctl_out  (ctl_f),
		.ang      (ang)
	);

	// lanes: here lat, goal lat, half dlat, half dlon
	hvd_rot u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_f),
		.ang     (ang),
		.ctl_out (ctl_r),
		.sin_v   (sin_v),
		.cos_v   (cos_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			ctl_s4    <= '0;
			ctl_s5    <= '0;
			ctl_s6    <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			ctl_s1    <= ctl_r;
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			ctl_s4    <= ctl_s3;
			ctl_s5    <= ctl_v;
			ctl_s6    <= ctl_s5;
			out_valid <= ctl_s6.valid;
		end
	end

	assign sum = 32'(t1_s3) + 32'(t2_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			c1_s1  <= clamp_pos(cos_v[0]);
			c2_s1  <= clamp_pos(cos_v[1]);
			sf_s1  <= clamp_abs(sin_v[2]);
			sl_s1  <= clamp_abs(sin_v[3]);
			t1_s2  <= 31'((62'(sf_s1) * 62'(sf_s1)) >> 30);
			c12_s2 <= 31'((62'(c1_s1) * 62'(c2_s1)) >> 30);
			sl2_s2 <= 31'((62'(sl_s1) * 62'(sl_s1)) >> 30);
			t1_s3  <= t1_s2;
			t2_s3  <= 31'((62'(c12_s2) * 62'(sl2_s2)) >> 30);
			a_s4   <= (sum > 32'(Q30_ONE)) ? 31'(Q30_ONE) : sum[30:0];
		end
	end

	assign sq_in[0] = a_s4;
	assign sq_in[1] = 31'(Q30_ONE) - a_s4;

	hvd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_s4),
		.v       (sq_in),
		.ctl_out (ctl_q),
		.root    (sq_out)
	);

	hvd_vec u_vec (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_q),
		.x_in    (sq_out[1]),
		.y_in    (sq_out[0]),
		.ctl_out (ctl_v),
		.z_out   (z_v)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s5  <= (z_v < 0) ? '0 : z_v[30:0];
			dist_s6 <= 26'((54'(RADIUS) * 54'(ang_s5)) >> 29);
			if (ctl_s6.no_pos)
				distance_m <= '0;
			else if (dist_s6 > 26'(DIST_CAP))
				distance_m <= DIST_CAP;
			else
				distance_m <= dist_s6[24:0];
			no_position <= ctl_s6.no_pos;
		end
	end

endmodule

>>> rtl/core/hvd_checker.sv
// Port-level checks for haversine_distance, attached by bind.
// Depends on hvd_pkg.
module hvd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [30:0] here_lat,
	input logic signed [31:0] here_lon,
	input logic signed [30:0] goal_lat,
	input logic signed [31:0] goal_lon,
	input logic               out_valid,
	input logic               out_ready,
	input logic [24:0]        distance_m,
	input logic               no_position
);
	import hvd_pkg::*;

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_m) && $stable(no_position))
		else $error("result changed while stalled");

	a_no_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_position |-> distance_m == '0)
		else $error("distance nonzero without position");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_m <= DIST_CAP)
		else $error("distance above half circumference");

	// pipeline only stalls when a result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);

>>> sim/haversine_distance_test.sv
// Self-checking bench for haversine_distance: random and corner-case position pairs,
// bursty requests, a stalling result side and a bit-exact fixed-point distance predictor.
// Depends on hvd_pkg and the haversine_distance RTL.
`timescale 1ns / 1ps

module haversine_distance_test;
	import hvd_pkg::*;

	typedef struct {
		logic signed [30:0] here_lat;
		logic signed [31:0] here_lon;
		logic signed [30:0] goal_lat;
		logic signed [31:0] goal_lon;
	} fix_pair_t;

	typedef struct {
		logic [24:0] metres;
		logic        nopos;
	} leg_t;

	localparam longint LAT_MAX = 900000000;
	localparam longint LON_MAX = 1800000000;
	localparam longint ONE_Q30 = 1073741824;
	localparam logic [63:0] DEG7_TO_RAD = 64'd8048910509;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [30:0] here_lat;
	logic signed [31:0] here_lon;
	logic signed [30:0] goal_lat;
	logic signed [31:0] goal_lon;
	logic               out_valid;
	logic               out_ready;
	logic [24:0]        distance_m;
	logic               no_position;

	fix_pair_t pending_fixes[$];
	leg_t      expected_legs[$];
	int        mismatches = 0;
	int        n_requests = 0;
	int        n_legs = 0;
	int        n_nopos = 0;
	int        n_capped = 0;
	logic      taken = 1'b0;
	int        burst_left = 0;
	int        gap_left = 0;
	logic      hold_off = 1'b0;
	int        cyc = 0;

	longint atan_lut[32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127,
		63, 31, 15, 8, 4, 2, 1, 0};

	haversine_distance dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.here_lat(here_lat), .here_lon(here_lon),
		.goal_lat(goal_lat), .goal_lon(goal_lon),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance_m(distance_m), .no_position(no_position)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// 1e-7 degree to Q30 radians, halved 'extra' times, rounded half up on magnitude
	function automatic longint deg7_to_q30(longint u, int extra);
		logic [63:0] mag;
		logic [63:0] r;
		int          sh;
		mag = u < 0 ? -u : u;
		sh = 32 + extra;
		r = (mag * DEG7_TO_RAD + (64'd1 << (sh - 1))) >> sh;
		return u < 0 ? -longint'(r) : longint'(r);
	endfunction

	task automatic rotate_q30(input longint ang, output longint s, output longint c);
		longint x, y, z, nx, ny;
		x = 652032874; y = 0; z = ang;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
			end
			x = nx; y = ny;
		end
		s = clip(y, -ONE_Q30, ONE_Q30);
		c = clip(x, -ONE_Q30, ONE_Q30);
	endtask

	function automatic longint vector_angle(longint y0, longint x0);
		longint x, y, z, nx, ny;
		x = x0; y = y0; z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
			end
			x = nx; y = ny;
		end
		return z < 0 ? 0 : z;
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] r, b;
		r = 0; b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b); r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic great_circle(input fix_pair_t f, output leg_t leg);
		longint lat1, lon1, lat2, lon2, dlat, dlon, s, c, c1, c2, sf, sl, a, ang;
		logic [63:0] t1, t2, sa, sb, d, cap;
		lat1 = f.here_lat; lon1 = f.here_lon; lat2 = f.goal_lat; lon2 = f.goal_lon;
		if (lat1 == 0 || lon1 == 0) begin
			leg.metres = 0; leg.nopos = 1'b1;
			return;
		end
		lat1 = clip(lat1, -LAT_MAX, LAT_MAX);
		lat2 = clip(lat2, -LAT_MAX, LAT_MAX);
		lon1 = clip(lon1, -LON_MAX, LON_MAX);
		lon2 = clip(lon2, -LON_MAX, LON_MAX);
		dlat = lat2 - lat1;
		dlon = lon2 - lon1;
		if (dlon > LON_MAX) dlon -= 2 * LON_MAX;
		if (dlon < -LON_MAX) dlon += 2 * LON_MAX;
		rotate_q30(deg7_to_q30(lat1, 0), s, c1);
		rotate_q30(deg7_to_q30(lat2, 0), s, c2);
		if (c1 < 0) c1 = 0;
		if (c2 < 0) c2 = 0;
		rotate_q30(deg7_to_q30(dlat, 1), sf, c);
		rotate_q30(deg7_to_q30(dlon, 1), sl, c);
		a = longint'(64'(sf * sf) >> 30);
		t1 = 64'(c1 * c2) >> 30;
		t2 = 64'(sl * sl) >> 30;
		a += longint'((t1 * t2) >> 30);
		a = clip(a, 0, ONE_Q30);
		sa = floor_root(64'(a) << 30);
		sb = floor_root(64'(ONE_Q30 - a) << 30);
		ang = vector_angle(longint'(sa), longint'(sb));
		d = (64'(EARTH_RADIUS_M) * 64'(ang)) >> 29;
		cap = (64'(EARTH_RADIUS_M) * 64'd3373259426) >> 30;
		if (d > cap) d = cap;
		leg.metres = d[24:0];
		leg.nopos = 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic signed [30:0] any_lat(int mode);
		case (mode)
			0: return 31'($urandom);
			1: return 31'($signed($urandom_range(1800000000)) - 900000000);
			default: return 31'($signed($urandom_range(2)) - 1);
		endcase
	endfunction

	function automatic logic signed [31:0] any_lon(int mode);
		case (mode)
			0: return 32'($urandom);
			1: return 32'(longint'($urandom_range(3600000000)) - 1800000000);
			default: return 32'($signed($urandom_range(2)) - 1);
		endcase
	endfunction

	task automatic queue_fix(longint a, longint b, longint c, longint d);
		fix_pair_t f;
		f.here_lat = 31'(a); f.here_lon = 32'(b);
		f.goal_lat = 31'(c); f.goal_lon = 32'(d);
		pending_fixes.push_back(f);
	endtask

	// request driver
	always @(negedge clk) begin
		fix_pair_t f;
		if (arst_n && !(in_valid && !taken)) begin
			if (gap_left > 0 || pending_fixes.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				f = pending_fixes.pop_front();
				in_valid <= 1'b1;
				here_lat <= f.here_lat; here_lon <= f.here_lon;
				goal_lat <= f.goal_lat; goal_lon <= f.goal_lon;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(30, 1);
					gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// result side stall pattern, its character chosen by bits 9:8 of the cycle counter
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (hold_off) out_ready <= 1'b0;
		else case (cyc[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(1));
			2'd2: out_ready <= cyc[1:0] != 2'd3;
			default: out_ready <= $urandom_range(9) != 0;
		endcase
	end

	// acceptance tracking, prediction and checking
	always @(posedge clk) begin
		fix_pair_t f;
		leg_t      want;
		taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			f.here_lat = here_lat; f.here_lon = here_lon;
			f.goal_lat = goal_lat; f.goal_lon = goal_lon;
			great_circle(f, want);
			expected_legs.push_back(want);
			n_requests++;
			if (want.nopos) n_nopos++;
			if (want.metres == DIST_CAP) n_capped++;
		end
		if (arst_n && out_valid && out_ready) begin
			n_legs++;
			if (expected_legs.size() == 0) begin
				flag_mismatch("unexpected result, distance", distance_m, 0);
			end else begin
				want = expected_legs.pop_front();
				if (distance_m !== want.metres)
					flag_mismatch("distance_m", distance_m, want.metres);
				if (no_position !== want.nopos)
					flag_mismatch("no_position", no_position, want.nopos);
			end
		end
	end

	// long result-side hold-off so the pipeline fills and backpressures
	initial begin
		wait (n_requests >= 500);
		@(negedge clk) hold_off <= 1'b1;
		repeat (300) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5000000;
		$display("[haversine_distance] ERROR");
		$finish;
	end

	initial begin
		int m, k;
		longint la, lo;
		arst_n = 1'b0;
		in_valid = 1'b0; out_ready = 1'b0;
		here_lat = '0; here_lon = '0; goal_lat = '0; goal_lon = '0;

		// no position: lat zero, lon zero, both zero
		queue_fix(0, 123456789, 450000000, 10);
		queue_fix(-300000000, 0, 450000000, 10);
		queue_fix(0, 0, -1, -1);
		// extremes of range and beyond (saturation), then tiny values near zero
		queue_fix(900000000, 1800000000, -900000000, -1800000000);
		queue_fix(-900000000, -1800000000, 900000000, 1800000000);
		queue_fix(1073741823, 2147483647, -1073741824, -2147483648);
		queue_fix(-1073741824, -2147483648, 1073741823, 2147483647);
		queue_fix(1, 1, 1, 1);
		queue_fix(-1, -1, -1, -1);
		queue_fix(1, 1, -1, -1);
		// antipodes, cap
		queue_fix(450000000, 300000000, -450000000, -1500000000);
		queue_fix(1, 1, -1, -1799999999);
		queue_fix(10, 900000000, -10, -900000000);
		// across the date line both ways
		queue_fix(100000000, 1790000000, 100000000, -1790000000);
		queue_fix(-100000000, -1795000000, -120000000, 1795000000);
		// poles, identical points, small steps
		queue_fix(900000000, 5, 900000000, 1000000000);
		queue_fix(-900000000, 7, 899999999, -7);
		queue_fix(523456789, 134567890, 523456789, 134567890);
		queue_fix(523456789, 134567890, 523456790, 134567891);
		queue_fix(-333333333, -666666666, -333333000, -666666000);

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (int n = 0; n < 1800; n++) begin
			m = $urandom_range(9);
			if (m < 2) begin
				queue_fix(any_lat(0), any_lon(0), any_lat(0), any_lon(0));
			end else if (m < 6) begin
				queue_fix(any_lat(1), any_lon(1), any_lat(1), any_lon(1));
			end else if (m < 9) begin
				// nearby target, the usual tracking case
				la = any_lat(1); lo = any_lon(1);
				k = $urandom_range(20);
				queue_fix(la, lo, la + $signed($urandom_range(2 << k)) - (1 << k),
					lo + $signed($urandom_range(2 << k)) - (1 << k));
			end else begin
				queue_fix(($urandom_range(3) == 0) ? 0 : any_lat(2),
					($urandom_range(3) == 0) ? 0 : any_lon(1), any_lat(1), any_lon(2));
			end
		end

		wait (pending_fixes.size() == 0 && !in_valid);
		wait (expected_legs.size() == 0);
		repeat (200) @(posedge clk);
		$display("Checked %0d requests, %0d results: %0d without position, %0d at the cap.",
			n_requests, n_legs, n_nopos, n_capped);
		if (mismatches == 0 && expected_legs.size() == 0)
			$display("[haversine_distance] OK");
		else
			$display("[haversine_distance] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/hvd_pkg.sv
rtl/core/hvd_front.sv
rtl/core/hvd_rot.sv
rtl/core/hvd_sqrt.sv
rtl/core/hvd_vec.sv
rtl/core/haversine_distance.sv
rtl/core/hvd_checker.sv
sim/haversine_distance_test.sv
